FILE: sv/rrse_pkg.sv
// Package for the rolling Roll spread estimator.
// Field widths, internal datapath widths, register codes and shared types.
// No dependencies.
package rrse_pkg;

    localparam int PRICE_W   = 24;
    localparam int CHG_W     = 25;
    localparam int SUM_W     = 33;
    localparam int SXY_W     = 58;
    localparam int PROD_W    = 50;
    localparam int ACC_W     = 68;
    localparam int NUM_W     = 64;
    localparam int DIV_W     = 80;
    localparam int DEN_W     = 24;
    localparam int TICKS_W   = 33;
    localparam int BPS_W     = 48;
    localparam int BPS_NUM_W = 47;
    localparam int PAIR_W    = 8;
    localparam int BARS_W    = 9;
    localparam int WIN_W     = 8;
    localparam int SHIFT_W   = 6;
    localparam int ITER_W    = 6;
    localparam int STEP_W    = 3;
    localparam int FRAC_W    = 16;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [BARS_W-1:0] BARS_MAX      = 9'd511;
    localparam logic [WIN_W-1:0]  WINDOW_RESET  = 8'd20;
    localparam logic [13:0]       BPS_SCALE     = 14'd10000;
    localparam logic [ITER_W-1:0] DIV_LAST      = 6'd39;
    localparam logic [ITER_W-1:0] SQRT_LAST     = 6'd31;
    localparam logic [STEP_W-1:0] STEP_LAST     = 3'd6;
    localparam logic [STEP_W-1:0] STEP_DRAIN    = 3'd7;
    localparam logic [NUM_W-1:0]  SQRT_BIT_INIT = 64'h4000_0000_0000_0000;

    // register index, taken from paddr[2]
    localparam logic REG_WINDOW_LENGTH = 1'b0;

    typedef enum logic [1:0] {
        TAG_NONE,
        TAG_PAIR,
        TAG_NUM
    } prod_tag_t;

    typedef enum logic {
        DIV_SPREAD,
        DIV_BPS
    } div_mode_t;

endpackage

FILE: sv/rolling_roll_spread_estimator_top.sv
// Top level of the rolling Roll spread estimator: change ring memory, scan,
// shared multiplier, shared radix-4 divider, square root and output register.
// Depends on rrse_pkg.
//
// Usage:
//   Input channel bar_valid/bar_stall carries one close_price per bar. Output
//   channel result_valid/result_stall carries spread_valid, spread_ticks
//   (Q25.8) and spread_bps (Q.8), one result per bar, in order.
//   window_length is written over the APB port at byte address 0 while idle.
// Processing:
//   One bar at a time. A bar with a negative covariance goes through a scan
//   of the ring through its single read port (the pair count n is
//   window_length - 1 at most), partial products on the shared 25x25
//   multiplier, the Q.16 divide, the square root and the bps divide. Invalid
//   bars and a non-negative covariance skip the divide and root stages.
// Reset: state and counters clear, window_length returns to 20. The ring
//   needs no clearing pass; entries are read only after they are written.
// Stall: a finished result waits in the output register; the next bar is taken
//   meanwhile and the block holds its own result until the register frees.
module rolling_roll_spread_estimator_top #(
    parameter int MAX_WINDOW = 256
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rrse_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [rrse_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [rrse_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    input  logic                                bar_valid,
    output logic                                bar_stall,
    input  logic [rrse_pkg::PRICE_W-1:0]        close_price,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic                                spread_valid,
    output logic [rrse_pkg::TICKS_W-1:0]        spread_ticks,
    output logic [rrse_pkg::BPS_W-1:0]          spread_bps
);

    localparam int PTR_W = $clog2(MAX_WINDOW);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAX_WINDOW - 1);
    localparam logic [10:0]      WIN_CAP  = 11'(MAX_WINDOW - 1);

    localparam int CHG_W   = rrse_pkg::CHG_W;
    localparam int SUM_W   = rrse_pkg::SUM_W;
    localparam int SXY_W   = rrse_pkg::SXY_W;
    localparam int PROD_W  = rrse_pkg::PROD_W;
    localparam int ACC_W   = rrse_pkg::ACC_W;
    localparam int NUM_W   = rrse_pkg::NUM_W;
    localparam int DIV_W   = rrse_pkg::DIV_W;
    localparam int DEN_W   = rrse_pkg::DEN_W;
    localparam int PAIR_W  = rrse_pkg::PAIR_W;
    localparam int BARS_W  = rrse_pkg::BARS_W;
    localparam int WIN_W   = rrse_pkg::WIN_W;
    localparam int SHIFT_W = rrse_pkg::SHIFT_W;
    localparam int ITER_W  = rrse_pkg::ITER_W;
    localparam int STEP_W  = rrse_pkg::STEP_W;
    localparam int TICKS_W = rrse_pkg::TICKS_W;
    localparam int BPS_W   = rrse_pkg::BPS_W;
    localparam int PRICE_W = rrse_pkg::PRICE_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_PROD,
        S_CHECK,
        S_DIV,
        S_SQRT,
        S_BPS,
        S_OUT
    } state_t;

    // control registers
    state_t                   state_reg, state_next;
    logic [WIN_W-1:0]         window_reg, window_next;
    logic [PTR_W-1:0]         ptr_reg, ptr_next;
    logic [PRICE_W-1:0]       prev_close_reg, prev_close_next;
    logic [BARS_W-1:0]        bars_seen_reg, bars_seen_next;
    logic [PAIR_W:0]          reads_left_reg, reads_left_next;
    logic [PTR_W-1:0]         rd_addr_reg, rd_addr_next;
    logic                     rd_vld_reg, rd_vld_next;
    logic                     first_reg, first_next;
    rrse_pkg::prod_tag_t      prod_tag_reg, prod_tag_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic [ITER_W-1:0]        iter_reg, iter_next;
    rrse_pkg::div_mode_t      div_mode_reg, div_mode_next;
    logic                     result_valid_reg, result_valid_next;
    logic                     spread_valid_reg, spread_valid_next;
    logic [TICKS_W-1:0]       spread_ticks_reg, spread_ticks_next;
    logic [BPS_W-1:0]         spread_bps_reg, spread_bps_next;

    // datapath registers
    logic [PRICE_W-1:0]       close_reg, close_next;
    logic [PAIR_W-1:0]        pair_count_reg, pair_count_next;
    logic signed [SUM_W-1:0]  sum_x_reg, sum_x_next;
    logic signed [SUM_W-1:0]  sum_y_reg, sum_y_next;
    logic signed [SXY_W-1:0]  sum_xy_reg, sum_xy_next;
    logic signed [CHG_W-1:0]  prev_chg_reg, prev_chg_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [SHIFT_W-1:0]       prod_shift_reg, prod_shift_next;
    logic                     prod_neg_reg, prod_neg_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic [DIV_W-1:0]         div_q_reg, div_q_next;
    logic [DEN_W-1:0]         div_rem_reg, div_rem_next;
    logic [DEN_W-1:0]         div_den_reg, div_den_next;
    logic [NUM_W-1:0]         sq_x_reg, sq_x_next;
    logic [NUM_W-1:0]         sq_r_reg, sq_r_next;
    logic [NUM_W-1:0]         sq_bit_reg, sq_bit_next;
    logic                     res_valid_reg, res_valid_next;
    logic [TICKS_W-1:0]       res_ticks_reg, res_ticks_next;
    logic [BPS_W-1:0]         res_bps_reg, res_bps_next;

    // ring memory
    logic signed [CHG_W-1:0]  ring_mem [MAX_WINDOW];
    logic signed [CHG_W-1:0]  ring_rd_reg;
    logic                     ring_we;
    logic                     ring_re;
    logic signed [CHG_W-1:0]  ring_wdata;

    // combinational helpers
    logic                     bar_accept;
    logic                     cfg_write;
    logic [10:0]              win_wide;
    logic [WIN_W-1:0]         win_eff;
    logic [BARS_W-1:0]        win_cmp;
    logic [PAIR_W-1:0]        pairs_new;
    logic signed [CHG_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic [SUM_W-1:0]         abs_x, abs_y;
    logic [SXY_W-1:0]         abs_xy;
    logic                     xy_sign_neg;
    logic signed [ACC_W-1:0]  acc_term;
    logic [NUM_W-1:0]         num_sat;
    logic [15:0]              n_sq;
    logic [DEN_W:0]           dv_t1, dv_t2;
    logic                     dv_ge1, dv_ge2;
    logic [DEN_W-1:0]         dv_r1, dv_r2;
    logic [DIV_W-1:0]         dv_q1, dv_q2;
    logic [NUM_W:0]           sq_sum;
    logic                     sq_ge;
    logic [NUM_W-1:0]         sq_r_new;
    logic [rrse_pkg::BPS_NUM_W-1:0] bps_num;

    assign pready       = 1'b1;
    assign bar_stall    = (state_reg != S_IDLE);
    assign bar_accept   = bar_valid && !bar_stall;
    assign cfg_write    = psel && penable && pwrite;
    assign result_valid = result_valid_reg;
    assign spread_valid = spread_valid_reg;
    assign spread_ticks = spread_ticks_reg;
    assign spread_bps   = spread_bps_reg;

    always_comb
    begin
        unique case (paddr[2])
            rrse_pkg::REG_WINDOW_LENGTH: prdata = rrse_pkg::CFG_DATA_W'(window_reg);
            default:                     prdata = '0;
        endcase
    end

    assign ring_we    = bar_accept;
    assign ring_wdata = CHG_W'(close_price) - CHG_W'(prev_close_reg);
    assign ring_re    = (state_reg == S_SCAN) && (reads_left_reg != '0);

    always_ff @(posedge clk)
    begin
        if (ring_we)
            ring_mem[ptr_reg] <= ring_wdata;
        if (ring_re)
            ring_rd_reg <= ring_mem[rd_addr_reg];
    end

    // pair count for the bar being accepted
    always_comb
    begin
        win_wide = 11'(window_reg);
        win_eff  = (win_wide > WIN_CAP) ? WIN_CAP[WIN_W-1:0] : window_reg;
        win_cmp  = BARS_W'(win_eff);
        if (win_eff < 8'd2 || bars_seen_reg < win_cmp)
            pairs_new = '0;
        else if (bars_seen_reg == win_cmp)
            pairs_new = win_eff - 8'd2;
        else
            pairs_new = win_eff - 8'd1;
    end

    assign abs_x  = sum_x_reg[SUM_W-1] ? SUM_W'(-sum_x_reg) : SUM_W'(sum_x_reg);
    assign abs_y  = sum_y_reg[SUM_W-1] ? SUM_W'(-sum_y_reg) : SUM_W'(sum_y_reg);
    assign abs_xy = sum_xy_reg[SXY_W-1] ? SXY_W'(-sum_xy_reg) : SXY_W'(sum_xy_reg);
    assign xy_sign_neg = sum_xy_reg[SXY_W-1];

    assign mul_p    = mul_a * mul_b;
    assign acc_term = ACC_W'($unsigned(prod_reg)) << prod_shift_reg;
    assign num_sat  = (acc_reg[ACC_W-1:NUM_W] != '0) ? '1 : acc_reg[NUM_W-1:0];
    assign n_sq     = 16'(pair_count_reg) * 16'(pair_count_reg);
    assign bps_num  = rrse_pkg::BPS_NUM_W'(res_ticks_reg) *
                      rrse_pkg::BPS_NUM_W'(rrse_pkg::BPS_SCALE);

    // two restoring steps per cycle
    always_comb
    begin
        dv_t1  = {div_rem_reg, div_q_reg[DIV_W-1]};
        dv_ge1 = dv_t1 >= {1'b0, div_den_reg};
        dv_r1  = dv_ge1 ? DEN_W'(dv_t1 - {1'b0, div_den_reg}) : dv_t1[DEN_W-1:0];
        dv_q1  = {div_q_reg[DIV_W-2:0], dv_ge1};
        dv_t2  = {dv_r1, dv_q1[DIV_W-1]};
        dv_ge2 = dv_t2 >= {1'b0, div_den_reg};
        dv_r2  = dv_ge2 ? DEN_W'(dv_t2 - {1'b0, div_den_reg}) : dv_t2[DEN_W-1:0];
        dv_q2  = {dv_q1[DIV_W-2:0], dv_ge2};
    end

    always_comb
    begin
        sq_sum   = {1'b0, sq_r_reg} + {1'b0, sq_bit_reg};
        sq_ge    = {1'b0, sq_x_reg} >= sq_sum;
        sq_r_new = sq_ge ? (sq_r_reg >> 1) + sq_bit_reg : (sq_r_reg >> 1);
    end

    always_comb
    begin
        state_next        = state_reg;
        window_next       = window_reg;
        ptr_next          = ptr_reg;
        prev_close_next   = prev_close_reg;
        bars_seen_next    = bars_seen_reg;
        reads_left_next   = reads_left_reg;
        rd_addr_next      = rd_addr_reg;
        rd_vld_next       = 1'b0;
        first_next        = first_reg;
        prod_tag_next     = rrse_pkg::TAG_NONE;
        step_next         = step_reg;
        iter_next         = iter_reg;
        div_mode_next     = div_mode_reg;
        result_valid_next = result_valid_reg;
        spread_valid_next = spread_valid_reg;
        spread_ticks_next = spread_ticks_reg;
        spread_bps_next   = spread_bps_reg;

        close_next        = close_reg;
        pair_count_next   = pair_count_reg;
        sum_x_next        = sum_x_reg;
        sum_y_next        = sum_y_reg;
        sum_xy_next       = sum_xy_reg;
        prev_chg_next     = prev_chg_reg;
        prod_next         = mul_p;
        prod_shift_next   = prod_shift_reg;
        prod_neg_next     = prod_neg_reg;
        acc_next          = acc_reg;
        div_q_next        = div_q_reg;
        div_rem_next      = div_rem_reg;
        div_den_next      = div_den_reg;
        sq_x_next         = sq_x_reg;
        sq_r_next         = sq_r_reg;
        sq_bit_next       = sq_bit_reg;
        res_valid_next    = res_valid_reg;
        res_ticks_next    = res_ticks_reg;
        res_bps_next      = res_bps_reg;

        mul_a = prev_chg_reg;
        mul_b = ring_rd_reg;

        if (cfg_write && paddr[2] == rrse_pkg::REG_WINDOW_LENGTH)
            window_next = pwdata[WIN_W-1:0];

        if (result_valid_reg && !result_stall)
            result_valid_next = 1'b0;

        // products land in the cycle after issue
        case (prod_tag_reg)
            rrse_pkg::TAG_PAIR: sum_xy_next = sum_xy_reg + SXY_W'(prod_reg);
            rrse_pkg::TAG_NUM:  acc_next = prod_neg_reg ? acc_reg - acc_term
                                                        : acc_reg + acc_term;
            default: ;
        endcase

        unique case (state_reg)
            S_IDLE:
            begin
                if (bar_accept)
                begin
                    close_next      = close_price;
                    prev_close_next = close_price;
                    ptr_next        = (ptr_reg == PTR_LAST) ? '0 : ptr_reg + 1'b1;
                    rd_addr_next    = (ptr_reg == '0) ? PTR_LAST : ptr_reg - 1'b1;
                    if (bars_seen_reg != rrse_pkg::BARS_MAX)
                        bars_seen_next = bars_seen_reg + 1'b1;
                    pair_count_next = pairs_new;
                    reads_left_next = (pairs_new == '0) ? '0
                                                        : (PAIR_W+1)'(pairs_new) + 1'b1;
                    first_next      = 1'b1;
                    sum_x_next      = '0;
                    sum_y_next      = '0;
                    sum_xy_next     = '0;
                    state_next      = S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (ring_re)
                begin
                    rd_vld_next     = 1'b1;
                    reads_left_next = reads_left_reg - 1'b1;
                    rd_addr_next    = (rd_addr_reg == '0) ? PTR_LAST : rd_addr_reg - 1'b1;
                end
                if (rd_vld_reg)
                begin
                    prev_chg_next = ring_rd_reg;
                    if (first_reg)
                        first_next = 1'b0;
                    else
                    begin
                        prod_tag_next = rrse_pkg::TAG_PAIR;
                        sum_x_next    = sum_x_reg + SUM_W'(prev_chg_reg);
                        sum_y_next    = sum_y_reg + SUM_W'(ring_rd_reg);
                    end
                end
                if (reads_left_reg == '0 && !rd_vld_reg && prod_tag_reg == rrse_pkg::TAG_NONE)
                begin
                    if (pair_count_reg == '0)
                    begin
                        res_valid_next = 1'b0;
                        res_ticks_next = '0;
                        res_bps_next   = '0;
                        state_next     = S_OUT;
                    end
                    else
                    begin
                        acc_next   = '0;
                        step_next  = '0;
                        state_next = S_PROD;
                    end
                end
            end

            // N = Sx*Sy - n*Sxy from partial products of Sx, Sy split at bit 17 and Sxy split at bits 20 and 40
            S_PROD:
            begin
                if (step_reg == rrse_pkg::STEP_DRAIN)
                    state_next = S_CHECK;
                else
                begin
                    prod_tag_next = rrse_pkg::TAG_NUM;
                    step_next     = step_reg + 1'b1;
                    prod_neg_next = sum_x_reg[SUM_W-1] ^ sum_y_reg[SUM_W-1];
                    case (step_reg)
                        3'd0:
                        begin
                            mul_a = CHG_W'(abs_x[16:0]);
                            mul_b = CHG_W'(abs_y[16:0]);
                            prod_shift_next = 6'd0;
                        end
                        3'd1:
                        begin
                            mul_a = CHG_W'(abs_x[16:0]);
                            mul_b = CHG_W'(abs_y[32:17]);
                            prod_shift_next = 6'd17;
                        end
                        3'd2:
                        begin
                            mul_a = CHG_W'(abs_x[32:17]);
                            mul_b = CHG_W'(abs_y[16:0]);
                            prod_shift_next = 6'd17;
                        end
                        3'd3:
                        begin
                            mul_a = CHG_W'(abs_x[32:17]);
                            mul_b = CHG_W'(abs_y[32:17]);
                            prod_shift_next = 6'd34;
                        end
                        3'd4:
                        begin
                            mul_a = CHG_W'(pair_count_reg);
                            mul_b = CHG_W'(abs_xy[19:0]);
                            prod_shift_next = 6'd0;
                            prod_neg_next   = !xy_sign_neg;
                        end
                        3'd5:
                        begin
                            mul_a = CHG_W'(pair_count_reg);
                            mul_b = CHG_W'(abs_xy[39:20]);
                            prod_shift_next = 6'd20;
                            prod_neg_next   = !xy_sign_neg;
                        end
                        default:
                        begin
                            mul_a = CHG_W'(pair_count_reg);
                            mul_b = CHG_W'(abs_xy[57:40]);
                            prod_shift_next = 6'd40;
                            prod_neg_next   = !xy_sign_neg;
                        end
                    endcase
                end
            end

            S_CHECK:
            begin
                res_valid_next = 1'b1;
                if (acc_reg[ACC_W-1] || acc_reg == '0)
                begin
                    res_ticks_next = '0;
                    res_bps_next   = '0;
                    state_next     = S_OUT;
                end
                else
                begin
                    div_q_next    = {num_sat, {rrse_pkg::FRAC_W{1'b0}}};
                    div_rem_next  = '0;
                    div_den_next  = DEN_W'(n_sq);
                    div_mode_next = rrse_pkg::DIV_SPREAD;
                    iter_next     = '0;
                    state_next    = S_DIV;
                end
            end

            S_DIV:
            begin
                div_q_next   = dv_q2;
                div_rem_next = dv_r2;
                iter_next    = iter_reg + 1'b1;
                if (iter_reg == rrse_pkg::DIV_LAST)
                begin
                    if (div_mode_reg == rrse_pkg::DIV_SPREAD)
                    begin
                        sq_x_next   = dv_q2[NUM_W-1:0];
                        sq_r_next   = '0;
                        sq_bit_next = rrse_pkg::SQRT_BIT_INIT;
                        iter_next   = '0;
                        state_next  = S_SQRT;
                    end
                    else
                    begin
                        res_bps_next = (dv_q2[DIV_W-1:BPS_W] != '0) ? '1 : dv_q2[BPS_W-1:0];
                        state_next   = S_OUT;
                    end
                end
            end

            S_SQRT:
            begin
                if (sq_ge)
                    sq_x_next = sq_x_reg - sq_sum[NUM_W-1:0];
                sq_r_next   = sq_r_new;
                sq_bit_next = sq_bit_reg >> 2;
                iter_next   = iter_reg + 1'b1;
                if (iter_reg == rrse_pkg::SQRT_LAST)
                begin
                    res_ticks_next = {sq_r_new[TICKS_W-2:0], 1'b0};
                    if (close_reg == '0)
                    begin
                        res_bps_next = '0;
                        state_next   = S_OUT;
                    end
                    else
                        state_next = S_BPS;
                end
            end

            S_BPS:
            begin
                div_q_next    = DIV_W'(bps_num);
                div_rem_next  = '0;
                div_den_next  = close_reg;
                div_mode_next = rrse_pkg::DIV_BPS;
                iter_next     = '0;
                state_next    = S_DIV;
            end

            S_OUT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_valid_next = 1'b1;
                    spread_valid_next = res_valid_reg;
                    spread_ticks_next = res_ticks_reg;
                    spread_bps_next   = res_bps_reg;
                    state_next        = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            window_reg       <= rrse_pkg::WINDOW_RESET;
            ptr_reg          <= '0;
            prev_close_reg   <= '0;
            bars_seen_reg    <= '0;
            reads_left_reg   <= '0;
            rd_addr_reg      <= '0;
            rd_vld_reg       <= 1'b0;
            first_reg        <= 1'b0;
            prod_tag_reg     <= rrse_pkg::TAG_NONE;
            step_reg         <= '0;
            iter_reg         <= '0;
            div_mode_reg     <= rrse_pkg::DIV_SPREAD;
            result_valid_reg <= 1'b0;
            spread_valid_reg <= 1'b0;
            spread_ticks_reg <= '0;
            spread_bps_reg   <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            window_reg       <= window_next;
            ptr_reg          <= ptr_next;
            prev_close_reg   <= prev_close_next;
            bars_seen_reg    <= bars_seen_next;
            reads_left_reg   <= reads_left_next;
            rd_addr_reg      <= rd_addr_next;
            rd_vld_reg       <= rd_vld_next;
            first_reg        <= first_next;
            prod_tag_reg     <= prod_tag_next;
            step_reg         <= step_next;
            iter_reg         <= iter_next;
            div_mode_reg     <= div_mode_next;
            result_valid_reg <= result_valid_next;
            spread_valid_reg <= spread_valid_next;
            spread_ticks_reg <= spread_ticks_next;
            spread_bps_reg   <= spread_bps_next;
        end
    end

    always_ff @(posedge clk)
    begin
        close_reg      <= close_next;
        pair_count_reg <= pair_count_next;
        sum_x_reg      <= sum_x_next;
        sum_y_reg      <= sum_y_next;
        sum_xy_reg     <= sum_xy_next;
        prev_chg_reg   <= prev_chg_next;
        prod_reg       <= prod_next;
        prod_shift_reg <= prod_shift_next;
        prod_neg_reg   <= prod_neg_next;
        acc_reg        <= acc_next;
        div_q_reg      <= div_q_next;
        div_rem_reg    <= div_rem_next;
        div_den_reg    <= div_den_next;
        sq_x_reg       <= sq_x_next;
        sq_r_reg       <= sq_r_next;
        sq_bit_reg     <= sq_bit_next;
        res_valid_reg  <= res_valid_next;
        res_ticks_reg  <= res_ticks_next;
        res_bps_reg    <= res_bps_next;
    end

    a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        bar_valid && !bar_stall |=> bar_stall)
        else $error("bar transfer not followed by busy");

    a_invalid_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !spread_valid |-> spread_ticks == '0 && spread_bps == '0)
        else $error("invalid result carries nonzero spread");

    a_ticks_even: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !spread_ticks[0])
        else $error("spread_ticks is not twice a root");

    a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> div_rem_reg < div_den_reg)
        else $error("divider remainder out of range");

endmodule
